FILE: hw/rtl/hinted_table_linear_interp_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table interpolator
// Same-cycle and next-cycle implication checks on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef HINTED_TABLE_LINEAR_INTERP_MACROS_SVH
`define HINTED_TABLE_LINEAR_INTERP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTLI_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htli check failed");

// antecedent implies consequent in the next cycle
`define HTLI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htli check failed");

`endif

FILE: hw/rtl/htli_pkg.sv
// ----------------------------------------------------------------------------
// htli_pkg
// Shared constants, codes and interface structs of the table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package htli_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 8;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RCNT_W      = ROW_W + 1;
  localparam int CCNT_W      = COL_W + 1;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;

  // divider: dividend up to |dy|*|dv| < 2^65, remainder below |dx| <= 2^32
  localparam int MAG_W  = DATA_W + 1;
  localparam int DIV_W  = 2 * DATA_W + 1;
  localparam int REM_W  = DATA_W + 2;
  localparam int QKEEP  = 34;
  localparam int STEP_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_EVAL     = 2'd1,
    OP_EVAL_ALL = 2'd2,
    OP_INVERSE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] query;
    logic signed [DATA_W-1:0] key_lo;
    logic signed [DATA_W-1:0] key_hi;
    logic signed [DATA_W-1:0] dest_lo;
    logic signed [DATA_W-1:0] dest_hi;
  } arith_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic                     zero_width;
  } arith_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hinted_table_linear_interp.sv
// ----------------------------------------------------------------------------
// hinted_table_linear_interp
// Piecewise-linear table lookup with a remembered segment and hunt search.
//
//   channel   signals                                   direction
//   input     in_valid/in_stall, op..item_value         in  (stall out)
//   result    out_valid/out_stall, result_value..last   out (stall in)
//   config    cfg_we, cfg_index, cfg_data               in, write only
//
// A table write is taken only while idle. A query reads the hint row and hunts
// one row per step, then per column reads the clamp row when clamped, skips the
// divider for a zero-width segment, or when bracketed reads the key rows once and
// the destination rows, dominated by the 65-step divider run twice per column.
// Reset clears control and the hint; the table has no clear pass.
// out_stall holds the result register; a new item is taken once the previous
// one has moved its last result into that register.
// ----------------------------------------------------------------------------
`default_nettype none

module hinted_table_linear_interp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           op,
  input  wire logic [htli_pkg::COL_W-1:0]           key_column,
  input  wire logic [htli_pkg::COL_W-1:0]           dest_column,
  input  wire logic [htli_pkg::ROW_W-1:0]           row_index,
  input  wire logic signed [htli_pkg::DATA_W-1:0]   item_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [htli_pkg::DATA_W-1:0]        result_value,
  output logic signed [htli_pkg::DATA_W-1:0]        result_slope,
  output logic [htli_pkg::COL_W-1:0]                result_column,
  output logic [htli_pkg::ROW_W-1:0]                segment_index,
  output logic                                      clamped,
  output logic                                      last,
  input  wire logic                                 cfg_we,
  input  wire logic [htli_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [htli_pkg::CFG_W-1:0]           cfg_data
);

  localparam int RW = htli_pkg::ROW_W;
  localparam int CW = htli_pkg::COL_W;
  localparam int DW = htli_pkg::DATA_W;
  localparam int NW = htli_pkg::RCNT_W;
  localparam int KW = htli_pkg::CCNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_H0_RD, S_H0_CMP, S_SC_RD, S_SC_CMP,
    S_KLO_RD, S_KLO_CAP, S_KHI_RD, S_KHI_CAP,
    S_DLO_RD, S_DLO_CAP, S_DHI_RD, S_DHI_CAP,
    S_AR_GO, S_AR_WAIT, S_CL_RD, S_CL_CAP, S_EMIT
  } state_t;

  state_t state;

  logic [NW-1:0] row_count;
  logic [KW-1:0] col_count;
  logic [RW-1:0] hint;

  logic [CW-1:0] kc, c, last_col;
  logic          inv, up, bracketed, clamp_hi;
  logic [RW-1:0] h, i, lo;
  logic signed [DW-1:0] v, key_lo, key_hi, dest_lo, dest_hi;
  logic signed [DW-1:0] res_value, res_slope;
  logic          res_clamped;

  logic [htli_pkg::ADDR_W-1:0] raddr;
  logic signed [DW-1:0]        rdata;
  logic                        we;

  htli_pkg::arith_req_t areq;
  htli_pkg::arith_rsp_t arsp;

  logic [NW-1:0] nm1_full, rc_sat;
  logic [RW-1:0] nm1, h_eff;
  logic [KW-1:0] cm1_full, cc_sat;
  logic [CW-1:0] cm1, kc_sat, dc_sat;
  logic          is_all, go_up, lt, hit, out_free, emit;
  htli_pkg::op_t op_c;

  assign op_c     = htli_pkg::op_t'(op);
  assign nm1_full = row_count - 1'b1;
  assign nm1      = nm1_full[RW-1:0];
  assign h_eff    = ({1'b0, hint} >= row_count) ? nm1 : hint;
  assign cm1_full = col_count - 1'b1;
  assign cm1      = cm1_full[CW-1:0];
  assign kc_sat   = ({1'b0, key_column} >= col_count) ? cm1 : key_column;
  assign dc_sat   = ({1'b0, dest_column} >= col_count) ? cm1 : dest_column;
  assign is_all   = (op_c == htli_pkg::OP_EVAL_ALL);

  always_comb begin
    rc_sat = cfg_data[NW-1:0];
    if (rc_sat < NW'(2)) begin
      rc_sat = NW'(2);
    end else if (rc_sat > NW'(htli_pkg::MAX_ROWS)) begin
      rc_sat = NW'(htli_pkg::MAX_ROWS);
    end
    cc_sat = cfg_data[KW-1:0];
    if (cc_sat == '0) begin
      cc_sat = KW'(1);
    end else if (cc_sat > KW'(htli_pkg::MAX_COLS)) begin
      cc_sat = KW'(htli_pkg::MAX_COLS);
    end
  end

  // hunt decisions; inverse mode searches a descending key column
  assign go_up = inv ? !(v > rdata) : (v >= rdata);
  assign lt    = v < rdata;
  assign hit   = inv ? (up ? !lt : (v <= rdata)) : (up ? lt : !lt);

  always_comb begin
    case (state)
      S_SC_RD:  raddr = {kc, i};
      S_KLO_RD: raddr = {kc, lo};
      S_KHI_RD: raddr = {kc, RW'(lo + 1'b1)};
      S_DLO_RD: raddr = {c, lo};
      S_DHI_RD: raddr = {c, RW'(lo + 1'b1)};
      S_CL_RD:  raddr = {c, clamp_hi ? nm1 : RW'(0)};
      default:  raddr = {kc, h};
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign we       = in_valid && !in_stall && (op_c == htli_pkg::OP_WRITE);
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == S_EMIT) && out_free;

  htli_table_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr ({key_column, row_index}),
    .wdata (item_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign areq.start   = (state == S_AR_GO);
  assign areq.query   = v;
  assign areq.key_lo  = key_lo;
  assign areq.key_hi  = key_hi;
  assign areq.dest_lo = dest_lo;
  assign areq.dest_hi = dest_hi;

  htli_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hint      <= '0;
      row_count <= NW'(2);
      col_count <= KW'(1);
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          htli_pkg::CFG_ROW_COUNT: begin
            row_count <= rc_sat;
            hint      <= rc_sat[NW-1:1];
          end
          htli_pkg::CFG_COL_COUNT: col_count <= cc_sat;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && op_c != htli_pkg::OP_WRITE) begin
            kc       <= kc_sat;
            c        <= is_all ? CW'(0) : dc_sat;
            last_col <= is_all ? cm1 : dc_sat;
            inv      <= (op_c == htli_pkg::OP_INVERSE);
            v        <= item_value;
            h        <= h_eff;
            hint     <= h_eff;
            state    <= S_H0_RD;
          end
        end
        S_H0_RD: state <= S_H0_CMP;
        S_H0_CMP: begin
          up <= go_up;
          if (go_up) begin
            if (h == nm1) begin
              bracketed <= 1'b0;
              clamp_hi  <= 1'b1;
              state     <= S_CL_RD;
            end else begin
              i     <= h + 1'b1;
              state <= S_SC_RD;
            end
          end else begin
            if (h == '0) begin
              bracketed <= 1'b0;
              clamp_hi  <= 1'b0;
              state     <= S_CL_RD;
            end else begin
              i     <= h - 1'b1;
              state <= S_SC_RD;
            end
          end
        end
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          if (hit) begin
            lo        <= up ? RW'(i - 1'b1) : i;
            hint      <= (up && !inv) ? RW'(i - 1'b1) : i;
            bracketed <= 1'b1;
            state     <= S_KLO_RD;
          end else if (up) begin
            if (i == nm1) begin
              bracketed <= 1'b0;
              clamp_hi  <= 1'b1;
              state     <= S_CL_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_SC_RD;
            end
          end else begin
            if (i == '0) begin
              bracketed <= 1'b0;
              clamp_hi  <= 1'b0;
              state     <= S_CL_RD;
            end else begin
              i     <= i - 1'b1;
              state <= S_SC_RD;
            end
          end
        end
        S_KLO_RD:  state <= S_KLO_CAP;
        S_KLO_CAP: begin
          key_lo <= rdata;
          state  <= S_KHI_RD;
        end
        S_KHI_RD:  state <= S_KHI_CAP;
        S_KHI_CAP: begin
          key_hi <= rdata;
          state  <= S_DLO_RD;
        end
        S_DLO_RD:  state <= S_DLO_CAP;
        S_DLO_CAP: begin
          dest_lo <= rdata;
          state   <= S_DHI_RD;
        end
        S_DHI_RD:  state <= S_DHI_CAP;
        S_DHI_CAP: begin
          dest_hi <= rdata;
          state   <= S_AR_GO;
        end
        S_AR_GO:   state <= S_AR_WAIT;
        S_AR_WAIT: begin
          if (arsp.done) begin
            res_value   <= arsp.value;
            res_slope   <= arsp.slope;
            res_clamped <= arsp.zero_width;
            state       <= S_EMIT;
          end
        end
        S_CL_RD:  state <= S_CL_CAP;
        S_CL_CAP: begin
          res_value   <= rdata;
          res_slope   <= '0;
          res_clamped <= 1'b1;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            result_value  <= res_value;
            result_slope  <= res_slope;
            result_column <= c;
            segment_index <= hint;
            clamped       <= res_clamped;
            last          <= (c == last_col);
            if (c == last_col) begin
              state <= S_IDLE;
            end else begin
              c     <= c + 1'b1;
              state <= bracketed ? S_DLO_RD : S_CL_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/htli_table_ram.sv
// ----------------------------------------------------------------------------
// htli_table_ram
// Column-major table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module htli_table_ram (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [htli_pkg::ADDR_W-1:0]    waddr,
  input  wire logic [htli_pkg::DATA_W-1:0]    wdata,
  input  wire logic [htli_pkg::ADDR_W-1:0]    raddr,
  output logic      [htli_pkg::DATA_W-1:0]    rdata
);

  logic [htli_pkg::DATA_W-1:0] mem [htli_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/htli_arith.sv
// ----------------------------------------------------------------------------
// htli_arith
// Segment arithmetic: slope = dy*2^16/dx and value = lo + dy*dv/dx, through a
// split multiplier and a radix-2 restoring divider, with both results saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module htli_arith (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire htli_pkg::arith_req_t req,
  output htli_pkg::arith_rsp_t      rsp
);

  localparam int DW = htli_pkg::DATA_W;
  localparam int MW = htli_pkg::MAG_W;
  localparam int VW = htli_pkg::DIV_W;
  localparam int RW = htli_pkg::REM_W;
  localparam int HALF = MW / 2;

  typedef enum logic [2:0] {
    A_IDLE, A_SLOPE, A_MUL0, A_MUL1, A_VAL, A_DONE
  } astate_t;

  astate_t state;

  logic signed [MW-1:0] dx_c, dy_c, dv_c;
  logic [MW-1:0]        mdx, mdy, mdv;
  logic                 neg_slope, neg_val;
  logic signed [DW-1:0] dest_lo;
  logic [VW-1:0]        dvd, quo, prod;
  logic [RW-1:0]        rem;
  logic [htli_pkg::STEP_W-1:0] cnt;

  logic [RW-1:0]        rem_sh, rem_nx;
  logic                 ge;
  logic [VW-1:0]        quo_nx, pp0, pp1;
  logic signed [DW+3:0] sum;
  logic [DW-1:0]        slope_sat, value_sat;

  logic signed [DW-1:0] value_r, slope_r;
  logic                 zero_r;

  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] x);
    mag = x[MW-1] ? MW'(-x) : MW'(x);
  endfunction

  assign dx_c = $signed({req.key_hi[DW-1], req.key_hi}) -
                $signed({req.key_lo[DW-1], req.key_lo});
  assign dy_c = $signed({req.dest_hi[DW-1], req.dest_hi}) -
                $signed({req.dest_lo[DW-1], req.dest_lo});
  assign dv_c = $signed({req.query[DW-1], req.query}) -
                $signed({req.key_lo[DW-1], req.key_lo});

  assign rem_sh = {rem[RW-2:0], dvd[VW-1]};
  assign ge     = rem_sh >= {1'b0, mdx};
  assign rem_nx = ge ? (rem_sh - {1'b0, mdx}) : rem_sh;
  assign quo_nx = {quo[VW-2:0], ge};

  // 33x17 and 33x16 partial products
  assign pp0 = VW'(mdy) * VW'(mdv[HALF:0]);
  assign pp1 = VW'(mdy) * VW'(mdv[MW-1:HALF+1]);

  always_comb begin
    if (neg_slope) begin
      slope_sat = (quo_nx > VW'(65'h80000000)) ? 32'h8000_0000 : DW'(~quo_nx + 1'b1);
    end else begin
      slope_sat = (quo_nx > VW'(65'h7FFFFFFF)) ? 32'h7FFF_FFFF : quo_nx[DW-1:0];
    end
  end

  always_comb begin
    sum = $signed({{4{dest_lo[DW-1]}}, dest_lo}) +
          (neg_val ? -$signed({2'b00, quo_nx[htli_pkg::QKEEP-1:0]})
                   :  $signed({2'b00, quo_nx[htli_pkg::QKEEP-1:0]}));
    if (sum > $signed(36'sh0_7FFF_FFFF)) begin
      value_sat = 32'h7FFF_FFFF;
    end else if (sum < $signed(-36'sh0_8000_0000)) begin
      value_sat = 32'h8000_0000;
    end else begin
      value_sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            mdx       <= mag(dx_c);
            mdy       <= mag(dy_c);
            mdv       <= mag(dv_c);
            neg_slope <= dy_c[MW-1] ^ dx_c[MW-1];
            neg_val   <= dy_c[MW-1] ^ dv_c[MW-1] ^ dx_c[MW-1];
            dest_lo   <= req.dest_lo;
            if (dx_c == '0) begin
              value_r <= req.dest_lo;
              slope_r <= '0;
              zero_r  <= 1'b1;
              state   <= A_DONE;
            end else begin
              zero_r <= 1'b0;
              dvd    <= VW'({mag(dy_c), 16'h0000});
              rem    <= '0;
              quo    <= '0;
              cnt    <= '0;
              state  <= A_SLOPE;
            end
          end
        end
        A_SLOPE: begin
          rem <= rem_nx;
          quo <= quo_nx;
          dvd <= {dvd[VW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == htli_pkg::STEP_W'(VW - 1)) begin
            slope_r <= slope_sat;
            state   <= A_MUL0;
          end
        end
        A_MUL0: begin
          prod  <= pp0;
          state <= A_MUL1;
        end
        A_MUL1: begin
          dvd   <= prod + {pp1[VW-HALF-2:0], (HALF+1)'(0)};
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= A_VAL;
        end
        A_VAL: begin
          rem <= rem_nx;
          quo <= quo_nx;
          dvd <= {dvd[VW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == htli_pkg::STEP_W'(VW - 1)) begin
            value_r <= value_sat;
            state   <= A_DONE;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done       = (state == A_DONE);
  assign rsp.value      = value_r;
  assign rsp.slope      = slope_r;
  assign rsp.zero_width = zero_r;

endmodule

`default_nettype wire

FILE: hw/rtl/htli_checker.sv
// ----------------------------------------------------------------------------
// htli_checker
// Port-level checks on the table interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hinted_table_linear_interp_macros.svh"

module htli_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic [1:0]                         op,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [htli_pkg::DATA_W-1:0] result_value,
  input wire logic signed [htli_pkg::DATA_W-1:0] result_slope,
  input wire logic                               clamped
);

  logic wr_xfer, query_xfer;

  assign wr_xfer    = in_valid && !in_stall && (op == htli_pkg::OP_WRITE);
  assign query_xfer = in_valid && !in_stall && (op != htli_pkg::OP_WRITE);

  // table writes complete in the transfer cycle
  `HTLI_ASSERT_NEXT(a_write_no_stall, wr_xfer, !in_stall)
  // a query occupies the block at least for the next cycle
  `HTLI_ASSERT_NEXT(a_query_busy, query_xfer, in_stall)
  // clamped results never carry a slope
  `HTLI_ASSERT_NOW(a_clamp_flat, out_valid && clamped, result_slope == '0)
  // a held result does not change
  `HTLI_ASSERT_NEXT(a_hold, out_valid && out_stall,
                    out_valid && $stable(result_value) && $stable(result_slope))

endmodule

bind hinted_table_linear_interp htli_checker u_htli_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .op           (op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .result_slope (result_slope),
  .clamped      (clamped)
);

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Table interpolator testbench
// Loads the table through the write op and runs evals, eval-all and inverse
// queries at several row/column settings. A cycle-free predictor of the hunt
// and interpolation builds the expected results, and a monitor compares each
// result transfer. Both channels idle at random, with one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic [2:0]         column;
    logic [7:0]         segment;
    logic               clamp;
    logic               fin;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = htli_pkg::OP_WRITE;
  logic [2:0] key_column = '0;
  logic [2:0] dest_column = '0;
  logic [7:0] row_index = '0;
  logic signed [31:0] item_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic signed [31:0] result_slope;
  logic [2:0] result_column;
  logic [7:0] segment_index;
  logic clamped;
  logic last;
  logic cfg_we = 1'b0;
  logic [htli_pkg::CFG_IDX_W-1:0] cfg_index = htli_pkg::CFG_ROW_COUNT;
  logic [htli_pkg::CFG_W-1:0] cfg_data = '0;

  hinted_table_linear_interp dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] table_copy [htli_pkg::MAX_COLS][htli_pkg::MAX_ROWS];
  int unsigned rows_used = 2;
  int unsigned cols_used = 1;
  int unsigned hint = 0;

  interp_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_queries = 0;
  int unsigned n_clamped = 0;
  int unsigned hold_off = 0;

  initial begin
    #100_000_000;
    $display("hinted_table_linear_interp: mismatch");
    $finish;
  end

  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic predict_query(input htli_pkg::op_t q_op, input int unsigned kc_in,
                               input int unsigned dc_in, input logic signed [31:0] v);
    int unsigned kc, dc, lo, hi, first, cnt;
    int i, n, h, kind;
    longint dx, dy, dv, sl;
    logic signed [127:0] prod, quo;
    interp_result_t r;
    kc = kc_in;
    dc = dc_in;
    lo = 0;
    hi = 0;
    kind = 0;
    n = rows_used;
    if (hint >= rows_used) hint = rows_used - 1;
    if (kc >= cols_used) kc = cols_used - 1;
    if (dc >= cols_used) dc = cols_used - 1;
    h = hint;
    if (q_op != htli_pkg::OP_INVERSE) begin
      if (v >= table_copy[kc][h]) begin
        kind = 2;
        for (i = h + 1; i < n; i++) if (v < table_copy[kc][i]) begin
          lo = i - 1; hi = i; hint = lo; kind = 0; break;
        end
      end else begin
        kind = 1;
        for (i = h - 1; i >= 0; i--) if (v >= table_copy[kc][i]) begin
          lo = i; hi = i + 1; hint = lo; kind = 0; break;
        end
      end
    end else begin
      if (v > table_copy[kc][h]) begin
        kind = 1;
        for (i = h - 1; i >= 0; i--) if (v <= table_copy[kc][i]) begin
          lo = i; hi = i + 1; hint = i; kind = 0; break;
        end
      end else begin
        // hunting down the rows of a descending key: hint lands on the upper row
        kind = 2;
        for (i = h + 1; i < n; i++) if (v >= table_copy[kc][i]) begin
          lo = i - 1; hi = i; hint = i; kind = 0; break;
        end
      end
    end
    first = (q_op == htli_pkg::OP_EVAL_ALL) ? 0 : dc;
    cnt = (q_op == htli_pkg::OP_EVAL_ALL) ? cols_used : 1;
    for (int k = 0; k < cnt; k++) begin
      r.column = 3'(first + k);
      r.segment = hint[7:0];
      r.fin = (k == cnt - 1);
      r.slope = '0;
      r.clamp = 1'b1;
      if (kind == 1) r.value = table_copy[r.column][0];
      else if (kind == 2) r.value = table_copy[r.column][rows_used - 1];
      else begin
        dx = longint'(table_copy[kc][hi]) - longint'(table_copy[kc][lo]);
        dy = longint'(table_copy[r.column][hi]) - longint'(table_copy[r.column][lo]);
        dv = longint'(v) - longint'(table_copy[kc][lo]);
        if (dx == 0) r.value = table_copy[r.column][lo];
        else begin
          sl = (dy * 65536) / dx;
          r.slope = sat32(sl);
          prod = dy;
          prod = prod * dv;
          quo = prod / dx;
          if (quo < 0) quo = -((-quo) & 128'h3_FFFF_FFFF);
          else quo = quo & 128'h3_FFFF_FFFF;
          r.value = sat32(quo + table_copy[r.column][lo]);
          r.clamp = 1'b0;
        end
      end
      if (r.clamp) n_clamped++;
      pending_results.push_back(r);
    end
    n_queries++;
  endtask

  // one input transfer, then a random gap
  task automatic send_item(input htli_pkg::op_t i_op, input int unsigned kc,
                           input int unsigned dc, input int unsigned row,
                           input logic signed [31:0] v, input bit no_gap = 0);
    int unsigned gap;
    op <= i_op;
    key_column <= 3'(kc);
    dest_column <= 3'(dc);
    row_index <= 8'(row);
    item_value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (i_op == htli_pkg::OP_WRITE) table_copy[kc[2:0]][row[7:0]] = v;
    else predict_query(i_op, kc[2:0], dc[2:0], v);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 30) == 0) gap = $urandom_range(10, 60);
    if (no_gap) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    // a trailing table write has no result to wait on
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [htli_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    int unsigned v;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= htli_pkg::CFG_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    v = data & 9'h1FF;
    if (idx == htli_pkg::CFG_ROW_COUNT) begin
      if (v < 2) v = 2;
      if (v > htli_pkg::MAX_ROWS) v = htli_pkg::MAX_ROWS;
      rows_used = v;
      hint = rows_used / 2;
    end else begin
      v = data & 4'hF;
      if (v < 1) v = 1;
      if (v > htli_pkg::MAX_COLS) v = htli_pkg::MAX_COLS;
      cols_used = v;
    end
  endtask

  // column 0 ascending, column 1 descending, others random; a few flat steps
  task automatic load_table(input bit fast);
    logic signed [31:0] up, down;
    int unsigned stepmax;
    stepmax = 32'hFFF0_0000 / rows_used;
    up = 32'sh8000_0000 + $urandom_range(0, 32'hFFFF);
    down = 32'sh7FFF_FFFF - $urandom_range(0, 32'hFFFF);
    for (int r = 0; r < rows_used; r++) begin
      send_item(htli_pkg::OP_WRITE, 0, $urandom, r, up, fast);
      if (cols_used > 1) send_item(htli_pkg::OP_WRITE, 1, $urandom, r, down, fast);
      for (int c = 2; c < cols_used; c++)
        send_item(htli_pkg::OP_WRITE, c, $urandom, r, $urandom, fast);
      up = up + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, stepmax));
      down = down - (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, stepmax));
    end
  endtask

  function automatic logic signed [31:0] pick_value(input int unsigned kc);
    int unsigned r;
    r = $urandom_range(0, rows_used - 1);
    case ($urandom_range(0, 7))
      0: return table_copy[kc][r];
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      3: return $urandom;
      default: begin
        if (r == rows_used - 1) r--;
        return 32'((longint'(table_copy[kc][r]) + longint'(table_copy[kc][r + 1])) / 2
                   + longint'($signed($urandom_range(0, 6))) - 3);
      end
    endcase
  endfunction

  task automatic random_query;
    int unsigned sel, kc;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      kc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 0;
      send_item(htli_pkg::OP_EVAL, kc, $urandom, $urandom,
                pick_value(kc < cols_used ? kc : 0));
    end else if (sel < 6) begin
      kc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 0;
      send_item(htli_pkg::OP_EVAL_ALL, kc, $urandom, $urandom,
                pick_value(kc < cols_used ? kc : 0));
    end else if (sel < 9) begin
      kc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 1;
      send_item(htli_pkg::OP_INVERSE, kc, $urandom, $urandom,
                pick_value(kc < cols_used ? kc : 0));
    end else begin
      send_item(htli_pkg::OP_WRITE, $urandom_range(2, 7), 0,
                $urandom_range(0, rows_used - 1), $urandom);
    end
  endtask

  // result side: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 60) == 0) hold_off <= $urandom_range(10, 40);
    else out_stall <= out_stall & ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    interp_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{result_value, result_slope, result_column, segment_index, clamped, last};
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic test_directed;
    write_reg(htli_pkg::CFG_ROW_COUNT, 6);
    write_reg(htli_pkg::CFG_COL_COUNT, 4);
    load_table(0);
    send_item(htli_pkg::OP_EVAL, 0, 2, 0, table_copy[0][0]);
    send_item(htli_pkg::OP_EVAL, 0, 3, 0, table_copy[0][5]);
    send_item(htli_pkg::OP_EVAL, 0, 2, 0, 32'sh8000_0000);
    send_item(htli_pkg::OP_EVAL, 0, 2, 0, 32'sh7FFF_FFFF);
    send_item(htli_pkg::OP_EVAL, 7, 7, 0, pick_value(3));
    send_item(htli_pkg::OP_EVAL_ALL, 0, 0, 0, pick_value(0));
    send_item(htli_pkg::OP_EVAL_ALL, 0, 5, 0, table_copy[0][1]);
    send_item(htli_pkg::OP_INVERSE, 1, 2, 0, table_copy[1][0]);
    send_item(htli_pkg::OP_INVERSE, 1, 2, 0, table_copy[1][5]);
    send_item(htli_pkg::OP_INVERSE, 1, 0, 0, 32'sh7FFF_FFFF);
    send_item(htli_pkg::OP_INVERSE, 1, 3, 0, 32'sh8000_0000);
    send_item(htli_pkg::OP_INVERSE, 1, 3, 0, pick_value(1));
    // flat segment in the key column
    send_item(htli_pkg::OP_WRITE, 0, 0, 3, table_copy[0][2]);
    send_item(htli_pkg::OP_EVAL, 0, 1, 0, table_copy[0][2]);
    send_item(htli_pkg::OP_EVAL_ALL, 0, 0, 0, table_copy[0][2] + 1);
    // steep segment to saturate the slope
    send_item(htli_pkg::OP_WRITE, 0, 0, 4, table_copy[0][3] + 1);
    send_item(htli_pkg::OP_WRITE, 2, 0, 3, 32'sh8000_0000);
    send_item(htli_pkg::OP_WRITE, 2, 0, 4, 32'sh7FFF_FFFF);
    send_item(htli_pkg::OP_EVAL, 0, 2, 0, table_copy[0][3]);
  endtask

  task automatic test_random(input int unsigned rows, input int unsigned cols,
                             input int unsigned count);
    write_reg(htli_pkg::CFG_ROW_COUNT, rows);
    write_reg(htli_pkg::CFG_COL_COUNT, cols);
    load_table(0);
    repeat (count) random_query();
  endtask

  task automatic test_backpressure;
    // hold the output long enough that the input side backs up
    drain();
    hold_off = 400;
    repeat (12) send_item(htli_pkg::OP_EVAL_ALL, 0, 0, 0, pick_value(0), 1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 8);
    test_random(4, 15, 6);
    test_backpressure();
    test_random(1, 3, 10);
    test_random(12, 2, 15);
    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d queries with %0d results (%0d clamped or flat) over",
             n_queries, n_results, n_clamped);
    $display("row counts 2..12, column counts 1..8, with input and output stalls.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("hinted_table_linear_interp: match");
    end else begin
      $display("hinted_table_linear_interp: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
